[rtl/core/nsol_pkg.sv]
package nsol_pkg;

    // Default sizes of the layer
    localparam int HIDDEN_DEF       = 1024;
    localparam int BUCKETS_DEF      = 8;
    localparam int CLIP_MAX_DEF     = 255;
    localparam int WEIGHT_QUANT_DEF = 64;

    // Division by CLIP_MAX_DEF (255): multiply by the rounded-up reciprocal and
    // keep the bits above RECIP_SHIFT; exact for any 32-bit unsigned dividend.
    // Division by CLIP_MAX_DEF * WEIGHT_QUANT_DEF is a shift by WQ_SHIFT
    // (log2 of WEIGHT_QUANT_DEF) followed by the same step.
    localparam logic [31:0] RECIP_CLIP  = 32'h8080_8081;
    localparam int          RECIP_SHIFT = 39;
    localparam int          QUO_W       = 64 - RECIP_SHIFT;
    localparam int          WQ_SHIFT    = 6;

    // Transaction opcodes
    localparam logic [1:0] OP_LOAD_WEIGHT = 2'd0;
    localparam logic [1:0] OP_LOAD_BIAS   = 2'd1;
    localparam logic [1:0] OP_ACCUM       = 2'd2;

    // Configuration register map
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;
    localparam logic [CFG_IDX_W-1:0] CFG_EVAL_SCALE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_LIMIT = 1'b1;

    localparam logic [9:0]  EVAL_SCALE_RST  = 10'd400;
    localparam logic [14:0] SCORE_LIMIT_RST = 15'd31999;

    // Phase factor (52 + min(24, phase)) / 64
    localparam logic [6:0] PH_BASE  = 7'd52;
    localparam logic [5:0] PH_CAP   = 6'd24;
    localparam int         PH_SHIFT = 6;

    typedef struct packed {
        logic [1:0]         op;
        logic [2:0]         bucket;
        logic [10:0]        index;
        logic signed [15:0] value;
        logic [5:0]         phase;
        logic               last;
    } item_t;

    typedef logic signed [15:0] score_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_LD1,
        ST_DIV1,
        ST_BIAS,
        ST_SCALE,
        ST_LD2,
        ST_DIV2,
        ST_PHASE,
        ST_SHIFT,
        ST_OUT
    } state_t;

endpackage

[rtl/core/nsol_if.sv]
interface nsol_item_if;
    import nsol_pkg::*;

    logic  valid;
    logic  ready;
    item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface nsol_score_if;
    import nsol_pkg::*;

    logic   valid;
    logic   ready;
    score_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/nnue_screlu_output_layer_top.sv]
// Loads (weight or bias): accepted back to back, since the sequencer stays idle.
// Hidden values: a new one waits for the weight memory read and the multiply stage
// to finish, ahead of the running-sum add.
// Score: loaded into the output register in ST_OUT after the last hidden value is
// accepted (sum, two reciprocal divisions, bias, scale, phase, shift, clamp).
// ST_OUT waits while the previous score is still held.
// Reset: asynchronous, active low; clears control, running sum, configuration registers and output valid.
module nnue_screlu_output_layer_top #(
    parameter int HIDDEN       = nsol_pkg::HIDDEN_DEF,
    parameter int BUCKETS      = nsol_pkg::BUCKETS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    nsol_item_if.sink                       item,
    nsol_score_if.source                    result,
    input  logic                            cfg_we,
    input  logic [nsol_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nsol_pkg::CFG_DATA_W-1:0] cfg_data
);
    import nsol_pkg::*;

    // Memory geometry: one row of 2*HIDDEN weights per bucket
    localparam int ROW_LEN = 2 * HIDDEN;
    localparam int W_DEPTH = BUCKETS * ROW_LEN;
    localparam int AW      = $clog2(W_DEPTH);
    localparam int BKW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

    // Activation: clipped value and its square
    localparam int CLIP_MAX = CLIP_MAX_DEF;
    localparam int XW  = $clog2(CLIP_MAX + 1);
    localparam int SQW = 2 * XW;
    localparam int PW  = SQW + 17;

    // Post-sum datapath widths (exact, no wrap)
    localparam int T1_W = 34;
    localparam int T2_W = 45;
    localparam int Q2_W = QUO_W + 1;
    localparam int T3_W = Q2_W + 8;
    localparam int SH_W = T3_W - PH_SHIFT;
    localparam int T4_W = SH_W + 1;

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    logic accept;
    logic is_acc;
    logic out_load;

    assign accept   = item.valid && item.ready;
    assign is_acc   = (item.payload.op == OP_ACCUM);

    logic last_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept && is_acc) state_next = ST_MUL;
            ST_MUL:   state_next = last_reg ? ST_SUM : ST_IDLE;
            ST_SUM:   state_next = ST_LD1;
            ST_LD1:   state_next = ST_DIV1;
            ST_DIV1:  state_next = ST_BIAS;
            ST_BIAS:  state_next = ST_SCALE;
            ST_SCALE: state_next = ST_LD2;
            ST_LD2:   state_next = ST_DIV2;
            ST_DIV2:  state_next = ST_PHASE;
            ST_PHASE: state_next = ST_SHIFT;
            ST_SHIFT: state_next = ST_OUT;
            ST_OUT:   if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        item.ready = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: item.ready = 1'b1;
            ST_OUT:  out_load   = !result.valid || result.ready;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [9:0]  eval_scale_reg;
    logic [14:0] score_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eval_scale_reg  <= EVAL_SCALE_RST;
            score_limit_reg <= SCORE_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_EVAL_SCALE:  eval_scale_reg  <= cfg_data[9:0];
                CFG_SCORE_LIMIT: score_limit_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Address decode of the incoming transaction
    // ------------------------------------------------------------------
    logic [BKW-1:0] bk_idx;
    logic           bk_ok;
    logic           addr_ok;
    logic [AW-1:0]  w_addr;

    assign bk_idx  = BKW'(item.payload.bucket);
    assign bk_ok   = int'(item.payload.bucket) < BUCKETS;
    assign addr_ok = bk_ok && (int'(item.payload.index) < ROW_LEN);
    assign w_addr  = AW'(int'(bk_idx) * ROW_LEN + int'(item.payload.index));

    // ------------------------------------------------------------------
    // Weight and bias memories (no reset, undefined until loaded)
    // ------------------------------------------------------------------
    logic signed [15:0] wmem [W_DEPTH];
    logic signed [15:0] bmem [BUCKETS];
    logic signed [15:0] w_rd_reg;
    logic signed [15:0] b_rd_reg;

    always_ff @(posedge clk)
    begin
        if (accept && item.payload.op == OP_LOAD_WEIGHT && addr_ok)
        begin
            wmem[w_addr] <= item.payload.value;
        end
        if (accept)
        begin
            w_rd_reg <= wmem[w_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && item.payload.op == OP_LOAD_BIAS && bk_ok)
        begin
            bmem[bk_idx] <= item.payload.value;
        end
        if (accept)
        begin
            b_rd_reg <= bmem[bk_idx];
        end
    end

    // ------------------------------------------------------------------
    // Accumulate path: clip and square at accept, weight multiply, then add
    // ------------------------------------------------------------------
    logic [XW-1:0]  x_clip;
    logic [SQW-1:0] sq_reg;
    logic           wok_reg;
    logic           bok_reg;
    logic [5:0]     phase_reg;

    always_comb
    begin
        if (item.payload.value < 0)
            x_clip = '0;
        else if (item.payload.value > CLIP_MAX)
            x_clip = XW'(CLIP_MAX);
        else
            x_clip = XW'(item.payload.value);
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_acc)
        begin
            sq_reg    <= SQW'(x_clip) * SQW'(x_clip);
            wok_reg   <= addr_ok;
            bok_reg   <= bk_ok;
            phase_reg <= item.payload.phase;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= 1'b0;
        end
        else if (accept && is_acc)
        begin
            last_reg <= item.payload.last;
        end
    end

    logic signed [15:0]   w_sel;
    logic signed [PW-1:0] prod_full;
    logic [31:0]          prod_reg;
    logic                 add_pend_reg;
    logic [31:0]          sum_reg;

    assign w_sel     = wok_reg ? w_rd_reg : 16'sd0;
    assign prod_full = PW'($signed({1'b0, sq_reg})) * PW'(w_sel);

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            prod_reg <= 32'(prod_full);
        end
    end

    // Running sum wraps at 32 bits; cleared once captured by the divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            add_pend_reg <= 1'b0;
            sum_reg      <= '0;
        end
        else
        begin
            add_pend_reg <= (state_reg == ST_MUL);
            if (add_pend_reg)
                sum_reg <= sum_reg + prod_reg;
            else if (state_reg == ST_LD1)
                sum_reg <= '0;
        end
    end

    // ------------------------------------------------------------------
    // Reciprocal division by CLIP_MAX on magnitudes, shared by both steps.
    // The second step drops the WEIGHT_QUANT factor with a plain shift first.
    // ------------------------------------------------------------------
    logic [63:0]      mprod_reg;
    logic [QUO_W-1:0] quo_reg;
    logic             neg_reg;
    logic [32:0]      sum_mag;
    logic [31:0]      div_in;

    logic signed [T2_W-1:0] t2_reg;
    logic [T2_W-1:0]        t2_mag;

    assign sum_mag = sum_reg[31] ? (33'd0 - {1'b1, sum_reg}) : {1'b0, sum_reg};
    assign t2_mag  = t2_reg[T2_W-1] ? (T2_W'(0) - t2_reg) : t2_reg;
    assign div_in  = (state_reg == ST_LD2) ? t2_mag[WQ_SHIFT +: 32] : sum_mag[31:0];

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LD1)
        begin
            mprod_reg <= {32'd0, div_in} * {32'd0, RECIP_CLIP};
            neg_reg   <= sum_reg[31];
        end
        else if (state_reg == ST_LD2)
        begin
            mprod_reg <= {32'd0, div_in} * {32'd0, RECIP_CLIP};
            neg_reg   <= t2_reg[T2_W-1];
        end
        if (state_reg == ST_DIV1 || state_reg == ST_DIV2)
        begin
            quo_reg <= mprod_reg[63:RECIP_SHIFT];
        end
    end

    // ------------------------------------------------------------------
    // Finish: bias, scale, phase factor, truncating shift, clamp
    // ------------------------------------------------------------------
    logic signed [T1_W-1:0] q1_s;
    logic signed [T1_W-1:0] t1_reg;
    logic signed [15:0]     bias_sel;
    logic signed [Q2_W-1:0] q2_s;
    logic [5:0]             ph_min;
    logic [6:0]             ph_fac;
    logic signed [T3_W-1:0] t3_reg;
    logic [T3_W-1:0]        t3_mag;
    logic [SH_W-1:0]        t3_sh;
    logic signed [T4_W-1:0] t4_reg;
    logic signed [T4_W-1:0] lim_pos;
    logic signed [T4_W-1:0] lim_neg;
    score_t                 score_sel;

    assign q1_s = neg_reg ? (T1_W'(0) - T1_W'(quo_reg)) : T1_W'(quo_reg);
    assign bias_sel = bok_reg ? b_rd_reg : 16'sd0;
    assign q2_s = neg_reg ? (Q2_W'(0) - {1'b0, quo_reg}) : {1'b0, quo_reg};
    assign ph_min = (phase_reg < PH_CAP) ? phase_reg : PH_CAP;
    assign ph_fac = PH_BASE + {1'b0, ph_min};
    assign t3_mag = t3_reg[T3_W-1] ? (T3_W'(0) - t3_reg) : t3_reg;
    assign t3_sh  = t3_mag[T3_W-1:PH_SHIFT];
    assign lim_pos = {{(T4_W-15){1'b0}}, score_limit_reg};
    assign lim_neg = T4_W'(0) - lim_pos;

    always_comb
    begin
        if (t4_reg > lim_pos)
            score_sel = 16'(lim_pos);
        else if (t4_reg < lim_neg)
            score_sel = 16'(lim_neg);
        else
            score_sel = 16'(t4_reg);
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_BIAS:  t1_reg <= q1_s + T1_W'(bias_sel);
            ST_SCALE: t2_reg <= T2_W'(t1_reg) * T2_W'($signed({1'b0, eval_scale_reg}));
            ST_PHASE: t3_reg <= T3_W'(q2_s) * T3_W'($signed({1'b0, ph_fac}));
            ST_SHIFT: t4_reg <= t3_reg[T3_W-1] ? (T4_W'(0) - {1'b0, t3_sh})
                                               : {1'b0, t3_sh};
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register: holds the score until the sink takes it
    // ------------------------------------------------------------------
    score_t score_reg;
    logic   ovalid_reg;

    always_ff @(posedge clk)
    begin
        if (out_load)
            score_reg <= score_sel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    assign result.valid   = ovalid_reg;
    assign result.payload = score_reg;

endmodule

[tb/sv/tb_nnue_screlu_output_layer_top.sv]
`timescale 1ns / 100ps

module tb_nnue_screlu_output_layer_top;
    import nsol_pkg::*;

    localparam int NUM_BUCKETS    = BUCKETS_DEF;
    localparam int ROW_LEN        = 2 * HIDDEN_DEF;
    localparam int RANDOM_ITEMS   = 120;   // random transactions per phase
    localparam int NUM_PHASES     = 6;
    localparam int SETTLE_CYCLES  = 120;   // margin for work still in flight
    localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction at all
    localparam int REPORT_LIMIT   = 10;

    // Code 3 is not decoded by the block; such transactions are dropped
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // ------------------------------------------------------------------
    // Scoreboard: shadow of the weight and bias memories, the running sum
    // and the two registers. A score is predicted on each accumulate
    // transaction flagged last and held until the block delivers it.
    // ------------------------------------------------------------------
    class layer_scoreboard;
        logic signed [15:0] weights [NUM_BUCKETS*ROW_LEN];
        logic signed [15:0] biases [NUM_BUCKETS];
        bit [31:0]          hidden_sum;
        int                 eval_scale;
        int                 score_limit;
        score_t             pending_scores [$];
        int                 failures;

        function new();
            hidden_sum  = '0;
            eval_scale  = int'(EVAL_SCALE_RST);
            score_limit = int'(SCORE_LIMIT_RST);
            failures    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_EVAL_SCALE:  eval_scale  = int'(data[9:0]);
                CFG_SCORE_LIMIT: score_limit = int'(data[14:0]);
                default: ;
            endcase
        endfunction

        // Post-sum arithmetic is exact in 64 bits; every division truncates
        function score_t predict_score(logic [2:0] bucket, logic [5:0] phase);
            longint t;
            longint ph;
            longint lim;
            t   = longint'($signed(hidden_sum)) / CLIP_MAX_DEF + longint'(biases[bucket]);
            t   = t * longint'(eval_scale) / (CLIP_MAX_DEF * WEIGHT_QUANT_DEF);
            ph  = (phase < PH_CAP) ? longint'(phase) : longint'(PH_CAP);
            t   = t * (longint'(PH_BASE) + ph) / (longint'(1) << PH_SHIFT);
            lim = longint'(score_limit);
            if (t > lim)
                t = lim;
            if (t < -lim)
                t = -lim;
            return score_t'(t);
        endfunction

        function void note_item(item_t it);
            int slot;
            int x;
            int w;
            slot = int'(it.bucket) * ROW_LEN + int'(it.index);
            case (it.op)
                OP_LOAD_WEIGHT: weights[slot] = it.value;
                OP_LOAD_BIAS:   biases[it.bucket] = it.value;
                OP_ACCUM:
                begin
                    x = int'(it.value);
                    if (x < 0)
                        x = 0;
                    else if (x > CLIP_MAX_DEF)
                        x = CLIP_MAX_DEF;
                    w = int'(weights[slot]);
                    // 32-bit wrapping sum of clip^2 * weight
                    hidden_sum += 32'(x * x * w);
                    if (it.last)
                    begin
                        pending_scores.push_back(predict_score(it.bucket, it.phase));
                        hidden_sum = '0;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_score(score_t got);
            score_t want;
            if (pending_scores.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("score %0d delivered with none outstanding", got);
                return;
            end
            want = pending_scores.pop_front();
            if (got !== want)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("score mismatch: expected %0d, got %0d", want, got);
            end
        endfunction

        function int pending();
            return pending_scores.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, channels and the block itself
    // ------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    nsol_item_if  item_bus ();
    nsol_score_if score_bus ();

    nnue_screlu_output_layer_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_bus),
        .result    (score_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    layer_scoreboard board = new();

    // Stimulus bookkeeping: which weight slots hold a value, so that an
    // accumulate never reads an unwritten entry. Biases are all loaded
    // by the directed part before the first score is asked for.
    bit weight_loaded [NUM_BUCKETS][ROW_LEN];
    int loaded_idx [NUM_BUCKETS][$];
    int items_sent     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_request   = 1'b0;
    int quiet_cycles   = 0;
    bit item_taken;
    bit score_taken;

    // ------------------------------------------------------------------
    // Monitor: both channels are sampled on the rising edge. Inputs are
    // only ever changed on the falling edge, so the sampled values are
    // stable. The watchdog counts cycles in which neither channel moves.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            item_taken  = item_bus.valid && item_bus.ready;
            score_taken = score_bus.valid && score_bus.ready;
            if (item_taken)
                board.note_item(item_bus.payload);
            if (score_taken)
                board.check_score(score_bus.payload);
            if (item_taken || score_taken)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", quiet_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Score receiver: random back-pressure, or one long hold-off that it
    // counts itself while the sender keeps offering transactions.
    // ------------------------------------------------------------------
    initial
    begin
        score_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                score_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            else
                score_bus.ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Driver tasks. All are entered and left on a falling edge. valid is
    // left high after a transaction so back-to-back offers need only one
    // assignment per edge.
    // ------------------------------------------------------------------
    task automatic offer_item(input logic [1:0] op, input int b, input int idx,
                              input int value, input int phase, input bit last);
        item_t it;
        it.op     = op;
        it.bucket = 3'(b);
        it.index  = 11'(idx);
        it.value  = 16'(value);
        it.phase  = 6'(phase);
        it.last   = last;
        if (op == OP_LOAD_WEIGHT && !weight_loaded[b][idx])
        begin
            weight_loaded[b][idx] = 1'b1;
            loaded_idx[b].push_back(idx);
        end
        if (op != OP_UNUSED)
            items_sent++;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            item_bus.valid <= 1'b0;
            @(negedge clk);
        end
        item_bus.valid   <= 1'b1;
        item_bus.payload <= it;
        do
            @(posedge clk);
        while (!item_bus.ready);
        @(negedge clk);
    endtask

    // Sender goes quiet until every predicted score is back, then allows
    // for work still in flight on transactions that produce no score.
    task automatic wait_for_scores();
        item_bus.valid <= 1'b0;
        @(negedge clk);
        while (board.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(data);
        @(negedge clk);
        cfg_we <= 1'b0;
        board.set_reg(idx, CFG_DATA_W'(data));
        @(negedge clk);
    endtask

    // Hidden values: partly inside the clip window, partly at and beyond it
    function automatic int pick_hidden();
        int r;
        r = $urandom_range(99);
        if (r < 35)
            return $urandom_range(CLIP_MAX_DEF);
        if (r < 50)
        begin
            case ($urandom_range(4))
                0:       return -32768;
                1:       return 32767;
                2:       return 0;
                3:       return CLIP_MAX_DEF;
                default: return CLIP_MAX_DEF + 1;
            endcase
        end
        return int'($signed(16'($urandom)));
    endfunction

    // Small weights keep some scores clear of the clamp
    function automatic int pick_weight();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return -32768;
        if (r < 15)
            return 32767;
        if (r < 45)
            return int'($urandom_range(128)) - 64;
        return int'($signed(16'($urandom)));
    endfunction

    // One evaluation: optional weight and bias loads for a bucket, then a
    // run of hidden values from written slots, closed by last unless the
    // sequence is meant to be left open.
    task automatic eval_sequence(input bit with_last);
        int b;
        int n;
        int idx;
        b = $urandom_range(NUM_BUCKETS - 1);
        if (loaded_idx[b].size() < 3 || $urandom_range(99) < 35)
            repeat ($urandom_range(1, 4))
                offer_item(OP_LOAD_WEIGHT, b, $urandom_range(ROW_LEN - 1), pick_weight(),
                           $urandom_range(63), 1'($urandom_range(1)));
        if ($urandom_range(99) < 10)
            offer_item(OP_LOAD_BIAS, b, $urandom_range(ROW_LEN - 1), pick_weight(),
                       $urandom_range(63), 1'($urandom_range(1)));
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
        begin
            idx = loaded_idx[b][$urandom_range(loaded_idx[b].size() - 1)];
            offer_item(OP_ACCUM, b, idx, pick_hidden(), $urandom_range(63),
                       with_last && i == n - 1);
        end
    endtask

    task automatic random_step();
        int r;
        r = $urandom_range(99);
        if (r < 75)
            eval_sequence(1'b1);
        else if (r < 82)
            eval_sequence(1'b0);        // left open: sum carries into the next one
        else if (r < 90)
            offer_item($urandom_range(1) ? OP_LOAD_WEIGHT : OP_LOAD_BIAS,
                       $urandom_range(NUM_BUCKETS - 1), $urandom_range(ROW_LEN - 1),
                       pick_weight(), $urandom_range(63), 1'($urandom_range(1)));
        else
            offer_item(OP_UNUSED, $urandom_range(NUM_BUCKETS - 1),
                       $urandom_range(ROW_LEN - 1), int'($signed(16'($urandom))),
                       $urandom_range(63), 1'($urandom_range(1)));
    endtask

    // ------------------------------------------------------------------
    // Test sequence. Six phases, each with its own idling pattern and
    // register setting; registers only change once the block has drained.
    //   phase 0: no idling, reset register values, directed part first
    //   phase 1: sender idle 61%, smallest scale and limit
    //   phase 2: receiver stalls 61%, largest scale and limit
    //   phase 3: both idle 38%, random registers
    //   phase 4: no idling, reset values written back explicitly
    //   phase 5: both idle 38%, largest scale with the tightest clamp
    // ------------------------------------------------------------------
    initial
    begin
        int phase_start;
        item_bus.valid   = 1'b0;
        item_bus.payload = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                1:
                begin
                    send_idle_pct  = 61;
                    recv_stall_pct = 0;
                    write_reg(CFG_EVAL_SCALE, 1);
                    write_reg(CFG_SCORE_LIMIT, 1);
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 61;
                    write_reg(CFG_EVAL_SCALE, 1023);
                    write_reg(CFG_SCORE_LIMIT, 32767);
                end
                3:
                begin
                    send_idle_pct  = 38;
                    recv_stall_pct = 38;
                    write_reg(CFG_EVAL_SCALE, $urandom_range(1, 1023));
                    write_reg(CFG_SCORE_LIMIT, $urandom_range(1, 32767));
                end
                4:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    write_reg(CFG_EVAL_SCALE, int'(EVAL_SCALE_RST));
                    write_reg(CFG_SCORE_LIMIT, int'(SCORE_LIMIT_RST));
                end
                5:
                begin
                    send_idle_pct  = 38;
                    recv_stall_pct = 38;
                    write_reg(CFG_EVAL_SCALE, 1023);
                    write_reg(CFG_SCORE_LIMIT, 1);
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase

            if (ph == 0)
            begin
                // Biases for every bucket, extremes on the end buckets; one
                // load carries last, which must not trigger a score
                for (int b = 0; b < NUM_BUCKETS; b++)
                    offer_item(OP_LOAD_BIAS, b, 0,
                               (b == 0) ? 32767 : (b == NUM_BUCKETS - 1) ? -32768 : pick_weight(),
                               0, b == 3);
                // Weights at both ends of a row and across the side boundary
                offer_item(OP_LOAD_WEIGHT, 0, 0, 32767, 0, 1'b0);
                offer_item(OP_LOAD_WEIGHT, 0, ROW_LEN - 1, -32768, 0, 1'b0);
                offer_item(OP_LOAD_WEIGHT, 0, HIDDEN_DEF, 1, 0, 1'b1);
                offer_item(OP_LOAD_WEIGHT, NUM_BUCKETS - 1, HIDDEN_DEF - 1, -1, 0, 1'b0);
                offer_item(OP_LOAD_WEIGHT, NUM_BUCKETS - 1, ROW_LEN - 1, 32767, 0, 1'b0);
                // Undecoded op with last set: dropped
                offer_item(OP_UNUSED, 5, 1365, -21846, 42, 1'b1);
                // Two full-clip products at the largest weight wrap the sum
                // negative; a negative hidden value clips to zero
                offer_item(OP_ACCUM, 0, 0, 32767, 0, 1'b0);
                offer_item(OP_ACCUM, 0, 0, 32767, 0, 1'b0);
                offer_item(OP_ACCUM, 0, ROW_LEN - 1, -32768, 0, 1'b0);
                offer_item(OP_ACCUM, 0, HIDDEN_DEF, CLIP_MAX_DEF, 63, 1'b1);
                // Small sum on the most negative bias, phase at zero
                offer_item(OP_ACCUM, NUM_BUCKETS - 1, ROW_LEN - 1, 1, 0, 1'b0);
                offer_item(OP_ACCUM, NUM_BUCKETS - 1, HIDDEN_DEF - 1, 200, 0, 1'b0);
                offer_item(OP_ACCUM, NUM_BUCKETS - 1, ROW_LEN - 1, 0, 0, 1'b1);
                // Large negative result driven into the clamp, phase at the cap
                offer_item(OP_ACCUM, 0, ROW_LEN - 1, CLIP_MAX_DEF, 24, 1'b1);

                // Sender pauses until every score is back, then the receiver
                // holds off while transactions keep coming
                wait_for_scores();
                hold_request = 1'b1;
            end

            phase_start = items_sent;
            while (items_sent < phase_start + RANDOM_ITEMS)
                random_step();
            wait_for_scores();
        end

        if (board.failures == 0 && board.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/nsol_pkg.sv
rtl/core/nsol_if.sv
rtl/core/nnue_screlu_output_layer_top.sv
tb/sv/tb_nnue_screlu_output_layer_top.sv
